/* sv/lfo_pkg.sv */
`timescale 1ns / 1ps

package lfo_pkg;

  localparam int TIME_W     = 32;
  localparam int DIV_STEPS  = 32;
  localparam int FRAC_STEPS = 16;
  localparam int TAIL_STEPS = 10;
  localparam int NUM_STAGES = DIV_STEPS + FRAC_STEPS + TAIL_STEPS;

  localparam logic [2:0] REG_START_DELAY   = 3'd0;
  localparam logic [2:0] REG_CYCLE_LENGTH  = 3'd1;
  localparam logic [2:0] REG_PHASE_OFFSET  = 3'd2;
  localparam logic [2:0] REG_WAVE_DEPTH    = 3'd3;
  localparam logic [2:0] REG_RANDOM_AMOUNT = 3'd4;
  localparam logic [2:0] REG_WAVE_MODE     = 3'd5;

  localparam logic [1:0] MODE_SIN     = 2'd0;
  localparam logic [1:0] MODE_RISING  = 2'd1;
  localparam logic [1:0] MODE_FALLING = 2'd2;
  localparam logic [1:0] MODE_RECT    = 2'd3;

  localparam logic [57:0] DEN_HALF  = 58'd335544320000;
  localparam logic [24:0] Y_MAX     = 25'd20480624;
  localparam logic [25:0] RECIP_625 = 26'd54975582;

  localparam logic [13:0] RND_TAB [256] = '{
    14'd3506,14'd4434,14'd1025,14'd9123,14'd7791,14'd2490,14'd723,14'd2305,
    14'd7900,14'd8002,14'd1816,14'd9170,14'd4863,14'd7451,14'd4717,14'd3184,
    14'd1211,14'd6895,14'd820,14'd9922,14'd7764,14'd4766,14'd4756,14'd8877,
    14'd8652,14'd3379,14'd2949,14'd5967,14'd5498,14'd9053,14'd1963,14'd9004,
    14'd8496,14'd2988,14'd127,14'd9287,14'd5479,14'd859,14'd1592,14'd3379,
    14'd2861,14'd3408,14'd2549,14'd7725,14'd859,14'd7275,14'd918,14'd2070,
    14'd4170,14'd1738,14'd2002,14'd1934,14'd6514,14'd6758,14'd820,14'd5166,
    14'd137,14'd3770,14'd1133,14'd5635,14'd2822,14'd3096,14'd4648,14'd6318,
    14'd6094,14'd4775,14'd605,14'd1572,14'd5635,14'd2197,14'd4961,14'd8506,
    14'd5605,14'd7510,14'd6230,14'd6475,14'd4785,14'd7148,14'd8545,14'd8965,
    14'd8896,14'd547,14'd898,14'd5410,14'd7305,14'd1719,14'd576,14'd7451,
    14'd5488,14'd1709,14'd3086,14'd8320,14'd4805,14'd7734,14'd9639,14'd898,
    14'd2520,14'd254,14'd2480,14'd8154,14'd2451,14'd7441,14'd6660,14'd8066,
    14'd4951,14'd2900,14'd4541,14'd9746,14'd49,14'd3086,14'd8711,14'd8945,
    14'd3643,14'd9609,14'd4355,14'd947,14'd1338,14'd4932,14'd8398,14'd6826,
    14'd6641,14'd1494,14'd5146,14'd1455,14'd9229,14'd4795,14'd2354,14'd1748,
    14'd5049,14'd4834,14'd9912,14'd7500,14'd2275,14'd6572,14'd5566,14'd7236,
    14'd9473,14'd107,14'd6982,14'd9531,14'd3203,14'd5693,14'd8477,14'd6846,
    14'd5303,14'd2842,14'd7793,14'd6641,14'd7773,14'd6201,14'd3477,14'd4424,
    14'd7695,14'd8623,14'd5879,14'd6924,14'd3418,14'd8232,14'd8682,14'd8467,
    14'd3076,14'd8594,14'd5977,14'd5352,14'd5166,14'd1543,14'd2588,14'd4648,
    14'd1660,14'd9570,14'd4180,14'd4863,14'd5264,14'd2656,14'd1709,14'd576,
    14'd5498,14'd9502,14'd7217,14'd3281,14'd5703,14'd693,14'd7705,14'd3398,
    14'd9326,14'd3584,14'd332,14'd2744,14'd1816,14'd9014,14'd1221,14'd4893,
    14'd7607,14'd7197,14'd254,14'd2773,14'd8740,14'd2842,14'd7422,14'd400,
    14'd2422,14'd1602,14'd5264,14'd7686,14'd4268,14'd6973,14'd8262,14'd9766,
    14'd6484,14'd5488,14'd3047,14'd2188,14'd6182,14'd752,14'd5596,14'd5508,
    14'd4336,14'd5928,14'd8262,14'd6162,14'd4941,14'd9482,14'd1055,14'd2549,
    14'd6680,14'd1309,14'd5322,14'd5420,14'd4160,14'd2754,14'd5830,14'd6582,
    14'd4355,14'd1094,14'd4268,14'd8623,14'd8076,14'd2539,14'd8398,14'd4561,
    14'd8027,14'd1445,14'd6748,14'd4209,14'd2207,14'd2344,14'd9727,14'd6543,
    14'd8271,14'd7988,14'd2705,14'd3213,14'd7471,14'd3770,14'd5762,14'd4150
  };

  typedef struct packed {
    logic        zero;
    logic [1:0]  mode;
    logic [10:0] r;
    logic [16:0] depth;
    logic [31:0] cl;
    logic [31:0] t;
    logic [31:0] rem;
    logic [7:0]  cnt;
    logic [15:0] p16;
    logic        sq;
    logic [1:0]  quad;
    logic [14:0] x;
    logic [14:0] x2;
    logic [10:0] a;
    logic [13:0] b;
    logic [13:0] tab;
    logic [23:0] rt;
    logic [23:0] weight;
    logic        neg;
    logic [16:0] mag;
    logic [40:0] mw;
    logic [57:0] num;
    logic [24:0] y;
    logic [16:0] res;
  } item_t;

endpackage

/* sv/lfo_waveform_evaluator.sv */
`timescale 1ns / 1ps

// LFO waveform evaluator.
// Input stream: s_tdata carries a 32-bit time value; one transaction per time
// point. Output stream: m_tdata carries the signed Q15 oscillator value at
// that time, one transaction per input, in order.
// Configuration: cfg_we, cfg_index, cfg_wdata write start delay, cycle
// length, phase offset, depth, random amount and mode; write only while idle.
// Throughput: one transaction per cycle while the output is not stalled; the
// phase is found by a 32-step restoring division for the cycle count and
// remainder, then 16 steps for the phase fraction, one quotient bit per
// pipeline stage, followed by ten arithmetic stages.
// Reset: synchronous; clears the pipeline valid bits and sets the registers
// to cycle length 1 and all others 0.
// Stall: when m_tready is low with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module lfo_waveform_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] time_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] wave_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] start_delay;
  logic [31:0] cycle_length;
  logic [31:0] phase_offset;
  logic [16:0] wave_depth;
  logic [10:0] random_amount;
  logic [1:0]  wave_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay   <= '0;
      cycle_length  <= 32'd1;
      phase_offset  <= '0;
      wave_depth    <= '0;
      random_amount <= '0;
      wave_mode     <= lfo_pkg::MODE_SIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfo_pkg::REG_START_DELAY:   start_delay   <= cfg_wdata;
        lfo_pkg::REG_CYCLE_LENGTH:  cycle_length  <= cfg_wdata;
        lfo_pkg::REG_PHASE_OFFSET:  phase_offset  <= cfg_wdata;
        lfo_pkg::REG_WAVE_DEPTH:    wave_depth    <= cfg_wdata[16:0];
        lfo_pkg::REG_RANDOM_AMOUNT: random_amount <= cfg_wdata[10:0];
        lfo_pkg::REG_WAVE_MODE:     wave_mode     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  localparam int N = lfo_pkg::NUM_STAGES;
  localparam int D = lfo_pkg::DIV_STEPS;
  localparam int F = lfo_pkg::FRAC_STEPS;

  logic           en;
  logic           vld [N+1];
  lfo_pkg::item_t st  [N+1];
  lfo_pkg::item_t first;

  assign en       = !vld[N] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[N];
  assign m_tdata  = st[N].res[15:0];

  always_comb begin
    first       = '0;
    first.zero  = (wave_depth == '0) || (s_tdata < start_delay);
    first.mode  = wave_mode;
    first.r     = (random_amount > 11'd1024) ? 11'd1024 : random_amount;
    first.depth = wave_depth;
    first.cl    = (cycle_length == '0) ? 32'd1 : cycle_length;
    first.t     = s_tdata - start_delay + phase_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= first;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    lfo_pkg::item_t c;
    lfo_pkg::item_t nx;

    assign c = st[i];

    if (i < D) begin : g_div
      logic [32:0] tmp;
      logic        ge;
      always_comb begin
        nx  = c;
        tmp = {c.rem, c.t[31]};
        ge  = tmp >= {1'b0, c.cl};
        nx.rem = ge ? 32'(tmp - {1'b0, c.cl}) : tmp[31:0];
        nx.cnt = {c.cnt[6:0], ge};
        nx.t   = {c.t[30:0], 1'b0};
      end
    end else if (i < D + F) begin : g_frac
      logic [32:0] tmp;
      logic        ge;
      always_comb begin
        nx  = c;
        tmp = {c.rem, 1'b0};
        ge  = tmp >= {1'b0, c.cl};
        if (i == D) begin
          nx.sq = tmp > {1'b0, c.cl};
        end
        nx.rem = ge ? 32'(tmp - {1'b0, c.cl}) : tmp[31:0];
        nx.p16 = {c.p16[14:0], ge};
      end
    end else if (i == D + F) begin : g_fold
      always_comb begin
        nx      = c;
        nx.quad = c.p16[15:14];
        nx.x    = c.p16[14] ? 15'(15'd16384 - {1'b0, c.p16[13:0]})
                            : {1'b0, c.p16[13:0]};
        nx.tab  = lfo_pkg::RND_TAB[8'(c.cnt + c.r[7:0])];
      end
    end else if (i == D + F + 1) begin : g_sq
      logic [29:0] m;
      always_comb begin
        nx    = c;
        m     = 30'(c.x) * 30'(c.x);
        nx.x2 = 15'(m >> 14);
        nx.rt = 24'(25'(c.r) * 25'(c.tab));
      end
    end else if (i == D + F + 2) begin : g_poly_a
      logic [25:0] m;
      logic [24:0] k;
      always_comb begin
        nx        = c;
        m         = 26'(c.x2) * 26'd1160;
        nx.a      = 11'(m >> 14);
        k         = 25'(11'd1024 - c.r) * 25'd10000;
        nx.weight = c.rt + 24'(k);
      end
    end else if (i == D + F + 3) begin : g_poly_b
      logic [28:0] m;
      always_comb begin
        nx   = c;
        m    = 29'(c.x2) * 29'(14'd10512 - 14'(c.a));
        nx.b = 14'(m >> 14);
      end
    end else if (i == D + F + 4) begin : g_wave
      logic [29:0] m;
      logic [15:0] s;
      logic [15:0] u;
      always_comb begin
        nx = c;
        m  = 30'(c.x) * 30'(15'd25736 - 15'(c.b));
        s  = 16'(m >> 14);
        u  = c.p16 + 16'h8000;
        unique case (c.mode)
          lfo_pkg::MODE_SIN: begin
            nx.mag = {s, 1'b0};
            nx.neg = c.quad[1];
          end
          lfo_pkg::MODE_RISING: begin
            nx.neg = !u[15];
            nx.mag = u[15] ? {2'b0, u[14:0]} : 17'(17'h08000 - {1'b0, u});
          end
          lfo_pkg::MODE_FALLING: begin
            nx.neg = u > 16'h8000;
            nx.mag = nx.neg ? 17'({1'b0, u} - 17'h08000) : 17'(17'h08000 - {1'b0, u});
          end
          lfo_pkg::MODE_RECT: begin
            nx.neg = !c.sq;
            nx.mag = 17'h08000;
          end
          default: begin
            nx.neg = 1'b0;
            nx.mag = '0;
          end
        endcase
      end
    end else if (i == D + F + 5) begin : g_mul_w
      always_comb begin
        nx    = c;
        nx.mw = 41'(c.mag) * 41'(c.weight);
      end
    end else if (i == D + F + 6) begin : g_mul_d
      always_comb begin
        nx     = c;
        nx.num = 58'(c.mw) * 58'(c.depth);
      end
    end else if (i == D + F + 7) begin : g_round
      logic [57:0] sum;
      logic [27:0] y;
      always_comb begin
        nx   = c;
        sum  = c.num + lfo_pkg::DEN_HALF;
        y    = sum[57:30];
        nx.y = (y > 28'(lfo_pkg::Y_MAX)) ? lfo_pkg::Y_MAX : y[24:0];
      end
    end else if (i == D + F + 8) begin : g_recip
      logic [50:0] m;
      always_comb begin
        nx     = c;
        m      = 51'(c.y) * 51'(lfo_pkg::RECIP_625);
        nx.res = 17'(m >> 35);
      end
    end else begin : g_sat
      always_comb begin
        nx = c;
        if (c.zero) begin
          nx.res = '0;
        end else if (c.neg) begin
          nx.res = 17'(17'h10000 - ((c.res > 17'd32768) ? 17'd32768 : c.res));
          nx.res[16] = 1'b0;
        end else begin
          nx.res = (c.res > 17'd32767) ? 17'd32767 : c.res;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nx;
      end
    end
  end

endmodule
